[rtl/ecrf_pkg.sv]
package ecrf_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int REPORT_LEN  = 6;
    localparam int REP_IDX_W   = $clog2(REPORT_LEN);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [7:0]        byte_t;

    // Input item function codes
    typedef enum logic [2:0] {
        FUNC_BUS_BYTE   = 3'd0,
        FUNC_READ_REQ   = 3'd1,
        FUNC_TXN_END    = 3'd2,
        FUNC_REPORT     = 3'd3,
        FUNC_REINIT     = 3'd4
    } func_t;

    // Emulation mode codes; the remaining code seeds like classic
    localparam logic [1:0] MODE_CLASSIC = 2'd0;
    localparam logic [1:0] MODE_PRO     = 2'd1;
    localparam logic [1:0] MODE_NUNCHUK = 2'd2;

    typedef enum logic [1:0] {
        ST_SEED,
        ST_IDLE,
        ST_READ,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
        byte_t data;
    } mem_wr_t;

    // Fixed store locations
    localparam addr_t CAL_BASE_A = 8'h20;
    localparam addr_t CAL_BASE_B = 8'h30;
    localparam addr_t ID_BASE    = 8'hFA;

    // Calibration checksum: two 0x55 seeds plus the first 14 calibration bytes
    localparam logic [15:0] CAL_SUM = 16'h0055 + 16'h0055
        + 16'h003F + 16'h0000 + 16'h0020 + 16'h003F + 16'h0000 + 16'h0020
        + 16'h001F + 16'h0000 + 16'h0010 + 16'h001F + 16'h0000 + 16'h0010;

    function automatic byte_t cal_byte(input logic [3:0] idx);
        byte_t b;
        case (idx)
            4'd0, 4'd3:  b = 8'h3F;
            4'd2, 4'd5:  b = 8'h20;
            4'd6, 4'd9:  b = 8'h1F;
            4'd8, 4'd11: b = 8'h10;
            4'd14:       b = CAL_SUM[15:8];
            4'd15:       b = CAL_SUM[7:0];
            default:     b = 8'h00;
        endcase
        return b;
    endfunction

    // Reset image of one store byte for the given mode
    function automatic byte_t seed_byte(input addr_t addr, input logic [1:0] mode);
        byte_t b;
        case (addr) inside
            8'h00, 8'h01:   b = 8'h20;
            8'h02:          b = 8'h10;
            8'h04, 8'h05:   b = 8'hFF;
            [8'h20:8'h3F]:  b = cal_byte(addr[3:0]);
            8'hFA:          b = (mode == MODE_PRO) ? 8'h01 : 8'h00;
            8'hFC:          b = 8'hA4;
            8'hFD:          b = 8'h20;
            8'hFE:          b = 8'h01;
            8'hFF:          b = (mode == MODE_NUNCHUK) ? 8'h00 : 8'h01;
            default:        b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/extension_controller_register_file.sv]
// Register file of a controller extension as seen by a serial bus slave: a 256-byte store
// in one synchronous RAM, an 8-bit cursor and an address flag. Bus bytes, transaction end
// and unused function codes are handled in the idle state; a read request moves to a read
// state that waits for a free output register to take the registered RAM byte, which then
// sits there, so the next item is taken while the result waits. A report update writes the
// six packed report bytes through the single RAM write port, one per cycle. Reinitialize
// runs the seeding pass, which writes the reset image into every entry, one entry per cycle.
// The same pass runs after reset, and s_ready stays low until it completes; configuration
// writes are taken at any time. The mode in effect is captured when a pass starts.
module extension_controller_register_file
    import ecrf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [7:0]  s_bus_byte,
    input  logic [7:0]  s_left_stick_x,
    input  logic [7:0]  s_left_stick_y,
    input  logic [7:0]  s_right_stick_x,
    input  logic [7:0]  s_right_stick_y,
    input  logic [7:0]  s_left_trigger,
    input  logic [7:0]  s_right_trigger,
    input  logic [14:0] s_pressed_buttons,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_byte
);

    state_t     state_reg, state_next;
    logic [1:0] mode_reg;
    logic [1:0] seed_mode_reg, seed_mode_next;
    addr_t      seed_cnt_reg, seed_cnt_next;
    addr_t      cursor_reg, cursor_next;
    logic       taken_reg, taken_next;
    logic       m_valid_reg, m_valid_next;
    byte_t      m_read_byte_reg, m_read_byte_next;
    logic [REP_IDX_W-1:0] rep_cnt_reg, rep_cnt_next;
    byte_t      rep_reg  [REPORT_LEN];
    byte_t      rep_next [REPORT_LEN];

    logic       accept;
    func_t      func;
    logic       out_free;
    mem_wr_t    wr;
    logic       rd_en;
    byte_t      rd_data;

    // Packed report fields
    logic [5:0] lx, ly;
    logic [4:0] rx, ry, lt, rt;
    byte_t      ly_inv, ry_inv;

    assign func     = func_t'(s_func);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_read_byte = m_read_byte_reg;

    ecrf_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (cursor_reg),
        .rd_data (rd_data)
    );

    // Report packing: Y axes inverted, sticks and triggers truncated to 6/5/5 bits
    always_comb begin
        ly_inv = ~s_left_stick_y;
        ry_inv = ~s_right_stick_y;
        lx = s_left_stick_x[7:2];
        ly = ly_inv[7:2];
        rx = s_right_stick_x[7:3];
        ry = ry_inv[7:3];
        lt = s_left_trigger[7:3];
        rt = s_right_trigger[7:3];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SEED: begin
                if (seed_cnt_reg == addr_t'(STORE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (func)
                        FUNC_READ_REQ: state_next = ST_READ;
                        FUNC_REPORT:   state_next = ST_REPORT;
                        FUNC_REINIT:   state_next = ST_SEED;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                // hold until the output register can take the byte
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_REPORT: begin
                if (rep_cnt_reg == REP_IDX_W'(REPORT_LEN - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        seed_mode_next   = seed_mode_reg;
        seed_cnt_next    = seed_cnt_reg;
        cursor_next      = cursor_reg;
        taken_next       = taken_reg;
        rep_cnt_next     = rep_cnt_reg;
        rep_next         = rep_reg;
        m_valid_next     = m_valid_reg;
        m_read_byte_next = m_read_byte_reg;
        wr.en            = 1'b0;
        wr.addr          = cursor_reg;
        wr.data          = s_bus_byte;
        rd_en            = 1'b0;

        // drop the result once the transfer completes
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_SEED: begin
                wr.en         = 1'b1;
                wr.addr       = seed_cnt_reg;
                wr.data       = seed_byte(seed_cnt_reg, seed_mode_reg);
                seed_cnt_next = seed_cnt_reg + addr_t'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    case (func)
                        FUNC_BUS_BYTE: begin
                            if (!taken_reg) begin
                                // first byte after the flag clears sets the cursor
                                cursor_next = s_bus_byte;
                                taken_next  = 1'b1;
                            end else begin
                                wr.en       = 1'b1;
                                cursor_next = cursor_reg + addr_t'(1);
                            end
                        end
                        FUNC_READ_REQ: begin
                            rd_en       = 1'b1;
                            cursor_next = cursor_reg + addr_t'(1);
                        end
                        FUNC_TXN_END: begin
                            taken_next = 1'b0;
                        end
                        FUNC_REPORT: begin
                            rep_next[0]  = {rx[4:3], lx};
                            rep_next[1]  = {rx[2:1], ly};
                            rep_next[2]  = {rx[0], lt[4:3], ry};
                            rep_next[3]  = {lt[2:0], rt};
                            rep_next[4]  = ~{s_pressed_buttons[14:8], 1'b0};
                            rep_next[5]  = ~s_pressed_buttons[7:0];
                            rep_cnt_next = '0;
                        end
                        FUNC_REINIT: begin
                            seed_mode_next = mode_reg;
                            seed_cnt_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_read_byte_next = rd_data;
                end
            end
            ST_REPORT: begin
                // write the head byte and advance the shift line
                wr.en   = 1'b1;
                wr.addr = addr_t'(rep_cnt_reg);
                wr.data = rep_reg[0];
                for (int i = 0; i < REPORT_LEN - 1; i++) begin
                    rep_next[i] = rep_reg[i+1];
                end
                rep_cnt_next = rep_cnt_reg + REP_IDX_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SEED;
            mode_reg      <= MODE_CLASSIC;
            seed_mode_reg <= MODE_CLASSIC;
            seed_cnt_reg  <= '0;
            cursor_reg    <= '0;
            taken_reg     <= 1'b0;
            rep_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            seed_mode_reg <= seed_mode_next;
            seed_cnt_reg  <= seed_cnt_next;
            cursor_reg    <= cursor_next;
            taken_reg     <= taken_next;
            rep_cnt_reg   <= rep_cnt_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        m_read_byte_reg <= m_read_byte_next;
        rep_reg         <= rep_next;
    end

`ifndef ASSERT_OFF
    a_read_enters_read_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && func == FUNC_READ_REQ) |=> state_reg == ST_READ)
        else $error("read request did not enter the read state");

    a_result_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_READ))
        else $error("result raised outside a read");

    a_no_write_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> !wr.en && !rd_en)
        else $error("RAM access while a read is pending");

    a_seed_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEED && seed_cnt_reg == addr_t'(STORE_DEPTH - 1))
        |=> state_reg == ST_IDLE && seed_cnt_reg == '0)
        else $error("seeding pass did not end after the last entry");

    a_report_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_REPORT |-> rep_cnt_reg < REP_IDX_W'(REPORT_LEN))
        else $error("report write past byte 5");
`endif

endmodule

[rtl/ecrf_store.sv]
module ecrf_store
    import ecrf_pkg::*;
(
    input  logic    aclk,
    input  mem_wr_t wr,
    input  logic    rd_en,
    input  addr_t   rd_addr,
    output byte_t   rd_data
);

    byte_t mem [STORE_DEPTH];
    byte_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
